/* src/ccc_pkg.sv */
// shared types, widths and constants of the cell carrying capacity pipeline
package ccc_pkg;

  localparam int ALT_W   = 15;
  localparam int NPP_W   = 20;
  localparam int CAP_W   = 24;
  localparam int FAC_W   = 16;
  localparam int LON_W   = 16;
  localparam int LAT_W   = 15;
  localparam int ALTF_W  = 9;
  localparam int WPROD_W = 2 * FAC_W;
  localparam int WMUL_W  = WPROD_W + CAP_W;
  localparam int WB_W    = WMUL_W - 16;
  localparam int CB_W    = FAC_W + CAP_W - 8;
  localparam int BSUM_W  = WB_W + 1;
  localparam int BONUS_W = CAP_W + 1;
  localparam int PROD_W  = NPP_W + CAP_W;
  localparam int QUOT_W  = PROD_W - NPP_W;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = QUOT_W / DIV_BITS_PER_STAGE;
  localparam int CFG_IDX_W = 3;

  // altitude damping between full and zero altitude, metres
  localparam logic signed [ALT_W-1:0] ALT_FULL = 15'sd1500;
  localparam logic signed [ALT_W-1:0] ALT_ZERO = 15'sd2500;
  // (d * 256) / 1000 computed as (d * ALT_RECIP) >> ALT_RECIP_SH, exact for d <= 1000
  localparam logic [18:0] ALT_RECIP = 19'd268436;
  localparam int ALT_RECIP_SH = 20;
  localparam int ALT_DIFF_W = 10;
  localparam logic [ALTF_W-1:0] ALT_FACTOR_ONE = 9'd256;

  // oceania box, hundredths of a degree, all bounds exclusive
  localparam logic signed [LON_W-1:0] BOX_LON_MIN = 16'sd11500;
  localparam logic signed [LON_W-1:0] BOX_LON_MAX = 16'sd15000;
  localparam logic signed [LAT_W-1:0] BOX_LAT_MIN = -15'sd1200;
  localparam logic signed [LAT_W-1:0] BOX_LAT_MAX = 15'sd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NPP_LOW  = 3'd0,
    CFG_NPP_HIGH = 3'd1,
    CFG_CAP_MIN  = 3'd2,
    CFG_CAP_MAX  = 3'd3,
    CFG_COAST_F  = 3'd4,
    CFG_LAT_LOW  = 3'd5,
    CFG_LAT_HIGH = 3'd6,
    CFG_WATER_F  = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    RAMP_FLOOR = 2'd0,
    RAMP_CEIL  = 2'd1,
    RAMP_DIV   = 2'd2
  } ramp_t;

  typedef struct packed {
    logic               land;
    ramp_t              ramp;
    logic               ovf;
    logic               last;
    logic [BONUS_W-1:0] bonus;
  } div_ctl_t;

endpackage

/* src/ccc_in_if.sv */
// cell item channel into the capacity pipeline
interface ccc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ccc_pkg::ALT_W-1:0]  altitude_m;
  logic [ccc_pkg::NPP_W-1:0]         base_npp;
  logic [ccc_pkg::NPP_W-1:0]         model_npp;
  logic signed [ccc_pkg::LON_W-1:0]  longitude;
  logic signed [ccc_pkg::LAT_W-1:0]  latitude;
  logic                              is_coastal;
  logic [ccc_pkg::FAC_W-1:0]         water_amount;
  logic                              last_cell_in;

  modport source (
    output valid, altitude_m, base_npp, model_npp, longitude, latitude,
           is_coastal, water_amount, last_cell_in,
    input  ready
  );

  modport sink (
    input  valid, altitude_m, base_npp, model_npp, longitude, latitude,
           is_coastal, water_amount, last_cell_in,
    output ready
  );
endinterface

/* src/ccc_out_if.sv */
// capacity result channel out of the capacity pipeline
interface ccc_out_if;
  logic                      valid;
  logic                      ready;
  logic [ccc_pkg::CAP_W-1:0] capacity;
  logic                      last_cell_out;

  modport source (
    output valid, capacity, last_cell_out,
    input  ready
  );

  modport sink (
    input  valid, capacity, last_cell_out,
    output ready
  );
endinterface

/* src/cell_carrying_capacity.sv */
// carrying capacity pipeline: one grid cell item in, one capacity item out
// throughput: one item per cycle while the output is not stalled; the 12 radix-4 divider stages set the depth
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// synchronous active-low reset clears valid bits and loads register defaults
module cell_carrying_capacity (
  input  logic                            clk,
  input  logic                            rst_n,
  ccc_in_if.sink                          in_item,
  ccc_out_if.source                       out_item,
  input  logic                            cfg_we,
  input  logic [ccc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ccc_pkg::CAP_W-1:0]       cfg_wdata
);

  localparam int NW  = ccc_pkg::NPP_W;
  localparam int CW  = ccc_pkg::CAP_W;
  localparam int QW  = ccc_pkg::QUOT_W;
  localparam int BW  = ccc_pkg::BONUS_W;
  localparam int DS  = ccc_pkg::DIV_STAGES;

  // configuration registers
  logic [NW-1:0]                       low_r, high_r;
  logic [CW-1:0]                       floor_r, ceil_r;
  logic [ccc_pkg::FAC_W-1:0]           cbf_r, wbf_r;
  logic signed [ccc_pkg::LAT_W-1:0]    lat_lo_r, lat_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r    <= '0;
      high_r   <= '1;
      floor_r  <= '0;
      ceil_r   <= '1;
      cbf_r    <= '0;
      lat_lo_r <= -15'sd9000;
      lat_hi_r <= 15'sd9000;
      wbf_r    <= '0;
    end else if (cfg_we) begin
      unique case (ccc_pkg::cfg_idx_t'(cfg_index))
        ccc_pkg::CFG_NPP_LOW:  low_r    <= cfg_wdata[NW-1:0];
        ccc_pkg::CFG_NPP_HIGH: high_r   <= cfg_wdata[NW-1:0];
        ccc_pkg::CFG_CAP_MIN:  floor_r  <= cfg_wdata;
        ccc_pkg::CFG_CAP_MAX:  ceil_r   <= cfg_wdata;
        ccc_pkg::CFG_COAST_F:  cbf_r    <= cfg_wdata[ccc_pkg::FAC_W-1:0];
        ccc_pkg::CFG_LAT_LOW:  lat_lo_r <= cfg_wdata[ccc_pkg::LAT_W-1:0];
        ccc_pkg::CFG_LAT_HIGH: lat_hi_r <= cfg_wdata[ccc_pkg::LAT_W-1:0];
        ccc_pkg::CFG_WATER_F:  wbf_r    <= cfg_wdata[ccc_pkg::FAC_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic out_vld_r;
  logic stall, adv;

  assign stall = out_vld_r && !out_item.ready;
  assign adv   = !stall;
  assign in_item.ready = adv;

  // stage 1: land check, altitude factor, oceania substitution, coast window, water product
  logic                              s1_vld_r;
  logic                              s1_land_r, s1_coast_r, s1_last_r;
  logic [ccc_pkg::ALTF_W-1:0]        s1_fac_r;
  logic [NW-1:0]                     s1_npp_r;
  logic [ccc_pkg::WPROD_W-1:0]       s1_wprod_r;

  logic signed [ccc_pkg::ALT_W-1:0]  alt_diff;
  logic [ccc_pkg::ALT_DIFF_W-1:0]    alt_d;
  logic [28:0]                       alt_mul;
  logic [ccc_pkg::ALTF_W-1:0]        fac_nxt;
  logic                              in_box;
  logic [NW-1:0]                     npp_nxt;
  logic                              coast_nxt;

  always_comb begin
    alt_diff = ccc_pkg::ALT_ZERO - in_item.altitude_m;
    alt_d    = alt_diff[ccc_pkg::ALT_DIFF_W-1:0];
    alt_mul  = 29'(alt_d) * 29'(ccc_pkg::ALT_RECIP);
    priority if (in_item.altitude_m < ccc_pkg::ALT_FULL) begin
      fac_nxt = ccc_pkg::ALT_FACTOR_ONE;
    end else if (in_item.altitude_m >= ccc_pkg::ALT_ZERO) begin
      fac_nxt = '0;
    end else begin
      fac_nxt = alt_mul[ccc_pkg::ALT_RECIP_SH +: ccc_pkg::ALTF_W];
    end
    in_box = (in_item.longitude > ccc_pkg::BOX_LON_MIN) &&
             (in_item.longitude < ccc_pkg::BOX_LON_MAX) &&
             (in_item.latitude > ccc_pkg::BOX_LAT_MIN) &&
             (in_item.latitude < ccc_pkg::BOX_LAT_MAX);
    npp_nxt = (in_box && (in_item.base_npp < low_r)) ? in_item.model_npp
                                                     : in_item.base_npp;
    coast_nxt = in_item.is_coastal && (in_item.latitude > lat_lo_r) &&
                (in_item.latitude < lat_hi_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_land_r  <= in_item.altitude_m > 15'sd0;
      s1_fac_r   <= fac_nxt;
      s1_npp_r   <= npp_nxt;
      s1_coast_r <= coast_nxt;
      s1_wprod_r <= ccc_pkg::WPROD_W'(in_item.water_amount) *
                    ccc_pkg::WPROD_W'(wbf_r);
      s1_last_r  <= in_item.last_cell_in;
    end
  end

  // stage 2: scaled npp and both bonus products
  logic                          s2_vld_r;
  logic                          s2_land_r, s2_last_r;
  logic [NW-1:0]                 s2_npp_r;
  logic [ccc_pkg::WB_W-1:0]      s2_wb_r;
  logic [ccc_pkg::CB_W-1:0]      s2_cb_r;

  logic [NW+ccc_pkg::ALTF_W-1:0]          npp_mul;
  logic [ccc_pkg::WMUL_W-1:0]             w_mul;
  logic [ccc_pkg::FAC_W+CW-1:0]           c_mul;

  always_comb begin
    npp_mul = (NW+ccc_pkg::ALTF_W)'(s1_npp_r) * (NW+ccc_pkg::ALTF_W)'(s1_fac_r);
    w_mul   = ccc_pkg::WMUL_W'(s1_wprod_r) * ccc_pkg::WMUL_W'(ceil_r);
    c_mul   = (ccc_pkg::FAC_W+CW)'(cbf_r) * (ccc_pkg::FAC_W+CW)'(ceil_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_land_r <= s1_land_r;
      s2_last_r <= s1_last_r;
      s2_npp_r  <= npp_mul[8 +: NW];
      s2_wb_r   <= w_mul[ccc_pkg::WMUL_W-1:16];
      s2_cb_r   <= s1_coast_r ? c_mul[ccc_pkg::FAC_W+CW-1:8] : '0;
    end
  end

  // stage 3: ramp decision, dividend product, divisor, clamped bonus sum
  logic                          s3_vld_r;
  logic                          s3_land_r, s3_last_r;
  ccc_pkg::ramp_t                s3_ramp_r;
  logic [ccc_pkg::PROD_W-1:0]    s3_prod_r;
  logic [NW-1:0]                 s3_dv_r;
  logic [BW-1:0]                 s3_bonus_r;

  ccc_pkg::ramp_t                ramp_nxt;
  logic [ccc_pkg::BSUM_W-1:0]    bsum;
  logic [BW-1:0]                 bonus_nxt;

  always_comb begin
    priority if (s2_npp_r < low_r) begin
      ramp_nxt = ccc_pkg::RAMP_FLOOR;
    end else if ((s2_npp_r > high_r) || (high_r == low_r)) begin
      ramp_nxt = ccc_pkg::RAMP_CEIL;
    end else begin
      ramp_nxt = ccc_pkg::RAMP_DIV;
    end
    bsum = ccc_pkg::BSUM_W'(s2_wb_r) + ccc_pkg::BSUM_W'(s2_cb_r);
    // anything at or above 2^24 already exceeds every ceiling
    if (bsum[ccc_pkg::BSUM_W-1:CW] != '0) begin
      bonus_nxt = {1'b1, {CW{1'b0}}};
    end else begin
      bonus_nxt = {1'b0, bsum[CW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_land_r  <= s2_land_r;
      s3_last_r  <= s2_last_r;
      s3_ramp_r  <= ramp_nxt;
      s3_prod_r  <= ccc_pkg::PROD_W'(s2_npp_r) * ccc_pkg::PROD_W'(ceil_r);
      s3_dv_r    <= high_r - low_r;
      s3_bonus_r <= bonus_nxt;
    end
  end

  // divider: entry stage checks quotient overflow, then two quotient bits per stage
  logic [DS:0]               dvv_r;
  logic [NW-1:0]             rem_r  [0:DS];
  logic [QW-1:0]             nlo_r  [0:DS];
  logic [QW-1:0]             q_r    [0:DS];
  logic [NW-1:0]             dvs_r  [0:DS];
  ccc_pkg::div_ctl_t         ctl_r  [0:DS];

  logic [NW-1:0]             rem_nxt [0:DS-1];
  logic [QW-1:0]             nlo_nxt [0:DS-1];
  logic [QW-1:0]             q_nxt   [0:DS-1];

  logic [NW-1:0]             prod_hi;

  assign prod_hi = s3_prod_r[ccc_pkg::PROD_W-1:QW];

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= prod_hi;
      nlo_r[0] <= s3_prod_r[QW-1:0];
      q_r[0]   <= '0;
      dvs_r[0] <= s3_dv_r;
      ctl_r[0] <= '{land:  s3_land_r,
                    ramp:  s3_ramp_r,
                    ovf:   prod_hi >= s3_dv_r,
                    last:  s3_last_r,
                    bonus: s3_bonus_r};
    end
  end

  for (genvar g = 0; g < DS; g++) begin : g_div
    always_comb begin
      logic [NW:0]   t;
      logic [NW-1:0] r;
      logic [QW-1:0] n;
      logic [QW-1:0] q;
      r = rem_r[g];
      n = nlo_r[g];
      q = q_r[g];
      for (int b = 0; b < ccc_pkg::DIV_BITS_PER_STAGE; b++) begin
        t = {r, n[QW-1]};
        n = {n[QW-2:0], 1'b0};
        if (t >= {1'b0, dvs_r[g]}) begin
          r = NW'(t - {1'b0, dvs_r[g]});
          q = {q[QW-2:0], 1'b1};
        end else begin
          r = t[NW-1:0];
          q = {q[QW-2:0], 1'b0};
        end
      end
      rem_nxt[g] = r;
      nlo_nxt[g] = n;
      q_nxt[g]   = q;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[g+1] <= rem_nxt[g];
        nlo_r[g+1] <= nlo_nxt[g];
        q_r[g+1]   <= q_nxt[g];
        dvs_r[g+1] <= dvs_r[g];
        ctl_r[g+1] <= ctl_r[g];
      end
    end
  end

  // final stage: ramp value plus bonus, capped at the ceiling; zero for cells not on land
  logic [CW-1:0]   out_cap_r;
  logic [CW-1:0]   out_lim_r;
  logic            out_last_r;

  ccc_pkg::div_ctl_t  fctl;
  logic [BW-1:0]      ramp_val;
  logic [BW:0]        total;
  logic [CW-1:0]      cap_nxt;

  always_comb begin
    fctl = ctl_r[DS];
    unique case (fctl.ramp)
      ccc_pkg::RAMP_FLOOR: ramp_val = {1'b0, floor_r};
      ccc_pkg::RAMP_CEIL:  ramp_val = {1'b0, ceil_r};
      ccc_pkg::RAMP_DIV:   ramp_val = fctl.ovf ? {1'b1, {CW{1'b0}}}
                                               : BW'(floor_r) + BW'(q_r[DS]);
      default:             ramp_val = {1'b0, ceil_r};
    endcase
    total = (BW+1)'(ramp_val) + (BW+1)'(fctl.bonus);
    if (!fctl.land) begin
      cap_nxt = '0;
    end else if (total > (BW+1)'(ceil_r)) begin
      cap_nxt = ceil_r;
    end else begin
      cap_nxt = total[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cap_r  <= cap_nxt;
      out_lim_r  <= ceil_r;
      out_last_r <= fctl.last;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      dvv_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_item.valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      dvv_r     <= {dvv_r[DS-1:0], s3_vld_r};
      out_vld_r <= dvv_r[DS];
    end
  end

  assign out_item.valid         = out_vld_r;
  assign out_item.capacity      = out_cap_r;
  assign out_item.last_cell_out = out_last_r;

`ifndef NO_ASSERTIONS
  a_cap_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_cap_r <= out_lim_r))
    else $error("capacity above captured ceiling");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dvv_r[DS] && !ctl_r[DS].ovf) |-> (rem_r[DS] < dvs_r[DS]))
    else $error("divider remainder not below divisor");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable({s1_vld_r, s2_vld_r, s3_vld_r, dvv_r, out_vld_r}))
    else $error("pipeline occupancy changed during stall");
`endif

endmodule

/* bench/tb_cell_carrying_capacity.sv */
// self-checking testbench for the cell carrying capacity pipeline
`timescale 1ns / 100ps

module tb_cell_carrying_capacity;

  localparam int NPP_MAX  = 2**ccc_pkg::NPP_W - 1;
  localparam int CAP_MAX  = 2**ccc_pkg::CAP_W - 1;
  localparam int FAC_MAX  = 2**ccc_pkg::FAC_W - 1;
  localparam int HOLD_CYC = 300;

  typedef struct {
    logic signed [ccc_pkg::ALT_W-1:0] altitude_m;
    logic [ccc_pkg::NPP_W-1:0]        base_npp;
    logic [ccc_pkg::NPP_W-1:0]        model_npp;
    logic signed [ccc_pkg::LON_W-1:0] longitude;
    logic signed [ccc_pkg::LAT_W-1:0] latitude;
    logic                             is_coastal;
    logic [ccc_pkg::FAC_W-1:0]        water_amount;
    logic                             last_cell_in;
  } cell_t;

  typedef struct {
    logic [ccc_pkg::CAP_W-1:0] capacity;
    logic                      last_cell;
  } capacity_t;

  typedef struct {
    logic [ccc_pkg::NPP_W-1:0]        npp_low;
    logic [ccc_pkg::NPP_W-1:0]        npp_high;
    logic [ccc_pkg::CAP_W-1:0]        cap_floor;
    logic [ccc_pkg::CAP_W-1:0]        cap_ceil;
    logic [ccc_pkg::FAC_W-1:0]        coast_f;
    logic signed [ccc_pkg::LAT_W-1:0] lat_low;
    logic signed [ccc_pkg::LAT_W-1:0] lat_high;
    logic [ccc_pkg::FAC_W-1:0]        water_f;
  } settings_t;

  typedef enum {RX_OPEN, RX_PATTERN} rx_mode_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [ccc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ccc_pkg::CAP_W-1:0]     cfg_wdata;

  ccc_in_if  in_ch ();
  ccc_out_if out_ch ();

  cell_carrying_capacity dut (
    .clk,
    .rst_n,
    .in_item   (in_ch),
    .out_item  (out_ch),
    .cfg_we,
    .cfg_index,
    .cfg_wdata
  );

  settings_t   regs;
  capacity_t   capacity_q[$];
  int          cells_sent;
  int          results_checked;
  int          mismatches;
  int          settings_used;
  rx_mode_t    rx_mode;
  int          rx_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic capacity_t predict_capacity(cell_t c);
    capacity_t   r;
    int          alt;
    logic [63:0] npp;
    logic [63:0] factor;
    logic [63:0] cap;
    bit          in_box;
    alt = c.altitude_m;
    cap = 0;
    if (alt > 0) begin
      if (alt < int'(ccc_pkg::ALT_FULL)) factor = 256;
      else if (alt >= int'(ccc_pkg::ALT_ZERO)) factor = 0;
      else factor = ((int'(ccc_pkg::ALT_ZERO) - alt) * 256) /
                    (int'(ccc_pkg::ALT_ZERO) - int'(ccc_pkg::ALT_FULL));
      in_box = c.longitude > ccc_pkg::BOX_LON_MIN && c.longitude < ccc_pkg::BOX_LON_MAX &&
               c.latitude > ccc_pkg::BOX_LAT_MIN && c.latitude < ccc_pkg::BOX_LAT_MAX;
      npp = (in_box && c.base_npp < regs.npp_low) ? c.model_npp : c.base_npp;
      npp = (npp * factor) >> 8;
      if (npp < regs.npp_low) cap = regs.cap_floor;
      else if (npp > regs.npp_high) cap = regs.cap_ceil;
      else if (regs.npp_high == regs.npp_low) cap = regs.cap_ceil;
      else cap = regs.cap_floor + (npp * regs.cap_ceil) / (64'(regs.npp_high) - regs.npp_low);
      if (c.is_coastal && c.latitude > regs.lat_low && c.latitude < regs.lat_high)
        cap += (64'(regs.coast_f) * regs.cap_ceil) >> 8;
      cap += (64'(c.water_amount) * regs.water_f * regs.cap_ceil) >> 16;
      if (cap > regs.cap_ceil) cap = regs.cap_ceil;
    end
    r.capacity  = cap[ccc_pkg::CAP_W-1:0];
    r.last_cell = c.last_cell_in;
    return r;
  endfunction

  function automatic cell_t cell_of(int alt, int base, int model, int lon, int lat,
                                    int coastal, int water, int last);
    cell_t c;
    c.altitude_m   = ccc_pkg::ALT_W'(alt);
    c.base_npp     = ccc_pkg::NPP_W'(base);
    c.model_npp    = ccc_pkg::NPP_W'(model);
    c.longitude    = ccc_pkg::LON_W'(lon);
    c.latitude     = ccc_pkg::LAT_W'(lat);
    c.is_coastal   = coastal[0];
    c.water_amount = ccc_pkg::FAC_W'(water);
    c.last_cell_in = last[0];
    return c;
  endfunction

  function automatic int clamp_npp(int v);
    return (v < 0) ? 0 : (v > NPP_MAX) ? NPP_MAX : v;
  endfunction

  function automatic int pick_npp();
    int lo;
    int hi;
    lo = (regs.npp_low < regs.npp_high) ? regs.npp_low : regs.npp_high;
    hi = (regs.npp_low < regs.npp_high) ? regs.npp_high : regs.npp_low;
    case ($urandom_range(0, 9))
      0, 1:       return $urandom_range(0, NPP_MAX);
      2, 3, 4, 5: return $urandom_range(lo, hi);
      6:          return clamp_npp(int'(regs.npp_low) + int'($urandom_range(0, 6)) - 3);
      7:          return clamp_npp(int'(regs.npp_high) + int'($urandom_range(0, 6)) - 3);
      8:          return $urandom_range(0, 4096);
      default:    return $urandom_range(0, 1) ? NPP_MAX : 0;
    endcase
  endfunction

  function automatic cell_t random_cell();
    int alt_edges[8] = '{-16384, 0, 1, 1499, 1500, 2499, 2500, 16383};
    int alt;
    int lon;
    int lat;
    int water;
    case ($urandom_range(0, 9))
      0:          alt = $urandom_range(0, 32767) - 16384;
      1:          alt = -int'($urandom_range(0, 16384));
      2, 3, 4, 5: alt = $urandom_range(1, 1499);
      6, 7:       alt = $urandom_range(1500, 2500);
      8:          alt = $urandom_range(2501, 16383);
      default:    alt = alt_edges[$urandom_range(0, 7)];
    endcase
    if ($urandom_range(0, 9) < 4) begin
      lon = $urandom_range(11501, 14999);
      lat = int'($urandom_range(0, 1298)) - 1199;
    end else begin
      lon = int'($urandom_range(0, 36000)) - 18000;
      lat = int'($urandom_range(0, 18000)) - 9000;
    end
    water = $urandom_range(0, 1) ? $urandom_range(0, 1024) : $urandom_range(0, FAC_MAX);
    return cell_of(alt, pick_npp(), pick_npp(), lon, lat, $urandom_range(0, 1), water,
                   ($urandom_range(0, 7) == 0));
  endfunction

  function automatic settings_t random_settings();
    settings_t s;
    int        a;
    int        b;
    s.npp_low  = $urandom_range(0, 2**18);
    s.npp_high = s.npp_low + $urandom_range(1, 2**18);
    case ($urandom_range(0, 5))
      0:       s.npp_high = s.npp_low;
      1:       s.npp_high = s.npp_low - $urandom_range(1, s.npp_low + 1);
      default: ;
    endcase
    s.cap_ceil  = $urandom_range(0, 1) ? $urandom_range(0, CAP_MAX) : $urandom_range(256, 2**20);
    s.cap_floor = ($urandom_range(0, 7) == 0) ? $urandom_range(0, CAP_MAX)
                                              : $urandom_range(0, s.cap_ceil / 2);
    s.coast_f   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, FAC_MAX) : $urandom_range(0, 128);
    s.water_f   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, FAC_MAX) : $urandom_range(0, 64);
    a = int'($urandom_range(0, 18000)) - 9000;
    b = int'($urandom_range(0, 18000)) - 9000;
    s.lat_low  = ccc_pkg::LAT_W'((a < b) ? a : b);
    s.lat_high = ccc_pkg::LAT_W'((a < b) ? b : a);
    return s;
  endfunction

  task automatic send_cell(cell_t c);
    in_ch.valid        = 1'b1;
    in_ch.altitude_m   = c.altitude_m;
    in_ch.base_npp     = c.base_npp;
    in_ch.model_npp    = c.model_npp;
    in_ch.longitude    = c.longitude;
    in_ch.latitude     = c.latitude;
    in_ch.is_coastal   = c.is_coastal;
    in_ch.water_amount = c.water_amount;
    in_ch.last_cell_in = c.last_cell_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    capacity_q.push_back(predict_capacity(c));
    cells_sent++;
    @(negedge clk);
  endtask

  task automatic idle_input(int cycles);
    in_ch.valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (capacity_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(ccc_pkg::cfg_idx_t idx, logic [ccc_pkg::CAP_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
  endtask

  task automatic apply_settings(settings_t s);
    write_reg(ccc_pkg::CFG_NPP_LOW,  ccc_pkg::CAP_W'(s.npp_low));
    write_reg(ccc_pkg::CFG_NPP_HIGH, ccc_pkg::CAP_W'(s.npp_high));
    write_reg(ccc_pkg::CFG_CAP_MIN,  s.cap_floor);
    write_reg(ccc_pkg::CFG_CAP_MAX,  s.cap_ceil);
    write_reg(ccc_pkg::CFG_COAST_F,  ccc_pkg::CAP_W'(s.coast_f));
    write_reg(ccc_pkg::CFG_LAT_LOW,  ccc_pkg::CAP_W'(s.lat_low));
    write_reg(ccc_pkg::CFG_LAT_HIGH, ccc_pkg::CAP_W'(s.lat_high));
    write_reg(ccc_pkg::CFG_WATER_F,  ccc_pkg::CAP_W'(s.water_f));
    cfg_we = 1'b0;
    regs   = s;
    settings_used++;
  endtask

  task automatic stream_cells(int n, bit gaps);
    int burst;
    burst = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      send_cell(random_cell());
      burst--;
      if (gaps && burst == 0) begin
        idle_input($urandom_range(1, 6));
        burst = $urandom_range(1, 16);
      end
    end
  endtask

  task automatic test_directed();
    settings_t s;
    rx_mode = RX_PATTERN;
    // register defaults straight after reset
    send_cell(cell_of(1, NPP_MAX, 0, 0, 0, 0, 0, 0));
    send_cell(cell_of(16383, 500000, 0, 0, 0, 1, FAC_MAX, 1));
    drain();
    s = '{25600, 512000, 2560, 1280000, 64, -3000, 3000, 16};
    apply_settings(s);
    send_cell(cell_of(-16384, NPP_MAX, NPP_MAX, -18000, -9000, 1, FAC_MAX, 1));
    send_cell(cell_of(0, 300000, 0, 0, 0, 0, 0, 0));
    send_cell(cell_of(1, 300000, 0, 0, 0, 0, 0, 0));
    send_cell(cell_of(1499, 300000, 0, 0, 0, 0, 0, 0));
    send_cell(cell_of(1500, 300000, 0, 0, 0, 0, 0, 0));
    send_cell(cell_of(2499, 300000, 0, 0, 0, 0, 0, 0));
    send_cell(cell_of(2500, 300000, 0, 0, 0, 0, 0, 0));
    // oceania box and its exclusive edges
    send_cell(cell_of(100, 1000, 300000, 12000, -500, 0, 0, 0));
    send_cell(cell_of(100, 1000, 300000, 11500, -500, 0, 0, 0));
    send_cell(cell_of(100, 1000, 300000, 15000, -500, 0, 0, 0));
    send_cell(cell_of(100, 1000, 300000, 12000, -1200, 0, 0, 0));
    send_cell(cell_of(100, 20000, NPP_MAX, 11501, -1199, 0, 0, 0));
    send_cell(cell_of(100, 30000, 0, 14999, 99, 0, 0, 1));
    send_cell(cell_of(100, 0, 0, 0, 0, 0, 0, 0));
    // coastal window is exclusive
    send_cell(cell_of(100, 100000, 0, 0, 2999, 1, 0, 0));
    send_cell(cell_of(100, 100000, 0, 0, 3000, 1, 0, 0));
    send_cell(cell_of(100, 100000, 0, 18000, 9000, 0, FAC_MAX, 0));
    drain();
  endtask

  task automatic test_ramp_corners();
    // zero ramp range
    apply_settings('{50000, 50000, 2560, 1280000, 0, -9000, 9000, 0});
    send_cell(cell_of(100, 50000, 0, 0, 0, 0, 0, 0));
    send_cell(cell_of(100, 49999, 0, 0, 0, 0, 0, 0));
    drain();
    // inverted limits
    apply_settings('{60000, 40000, 2560, 1280000, 0, -9000, 9000, 0});
    send_cell(cell_of(100, 50000, 0, 0, 0, 0, 0, 0));
    send_cell(cell_of(100, 70000, 0, 0, 0, 0, 0, 0));
    drain();
    // floor above the ceiling
    apply_settings('{25600, 512000, 1000000, 500000, 0, -9000, 9000, 0});
    send_cell(cell_of(100, 0, 0, 0, 0, 0, 0, 0));
    send_cell(cell_of(100, 300000, 0, 0, 0, 0, 0, 1));
    drain();
  endtask

  task automatic test_register_extremes();
    rx_mode = RX_PATTERN;
    apply_settings('{0, 0, 0, 0, 0, 0, 0, 0});
    stream_cells(50, 1'b1);
    drain();
    apply_settings('{NPP_MAX, NPP_MAX, CAP_MAX, CAP_MAX, FAC_MAX, -9000, 9000, FAC_MAX});
    stream_cells(50, 1'b1);
    drain();
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 5; p++) begin
      apply_settings(random_settings());
      rx_mode = (p == 0) ? RX_OPEN : RX_PATTERN;
      stream_cells(200, p != 0);
      drain();
    end
  endtask

  task automatic test_output_hold();
    apply_settings(random_settings());
    rx_mode = RX_OPEN;
    @(posedge clk);
    rx_hold = HOLD_CYC;
    @(negedge clk);
    stream_cells(150, 1'b0);
    drain();
  endtask

  initial begin : receiver
    bit level;
    int run;
    level = 1'b1;
    run   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ch.ready = 1'b0;
        rx_hold--;
      end else if (rx_mode == RX_OPEN) begin
        out_ch.ready = 1'b1;
      end else begin
        if (run == 0) begin
          level = !level;
          run   = level ? $urandom_range(1, 12) : $urandom_range(1, 5);
        end
        out_ch.ready = level;
        run--;
      end
    end
  end

  always @(posedge clk) begin : check_results
    capacity_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (capacity_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: capacity item %0d with nothing pending", $realtime, out_ch.capacity);
        mismatches++;
      end else begin
        want = capacity_q.pop_front();
        results_checked++;
        if (out_ch.capacity !== want.capacity || out_ch.last_cell_out !== want.last_cell) begin
          if (mismatches < 10)
            $display("%0t: capacity %0d last %b, expected %0d last %b", $realtime,
                     out_ch.capacity, out_ch.last_cell_out, want.capacity, want.last_cell);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.altitude_m   = '0;
    in_ch.base_npp     = '0;
    in_ch.model_npp    = '0;
    in_ch.longitude    = '0;
    in_ch.latitude     = '0;
    in_ch.is_coastal   = 1'b0;
    in_ch.water_amount = '0;
    in_ch.last_cell_in = 1'b0;
    rx_mode            = RX_OPEN;
    rx_hold            = 0;
    cells_sent         = 0;
    results_checked    = 0;
    mismatches         = 0;
    settings_used      = 0;
    regs = '{0, NPP_MAX, 0, CAP_MAX, 0, -9000, 9000, 0};
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_ramp_corners();
    test_register_extremes();
    test_random_settings();
    test_output_hold();
    drain();
    repeat (40) @(negedge clk);
    $display("%0d cells sent, %0d capacities checked, %0d register settings written",
             cells_sent, results_checked, settings_used);
    $display("covered altitude, box, ramp and coast edges plus a %0d-cycle output hold",
             HOLD_CYC);
    if (mismatches == 0 && capacity_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* sim.f */
src/ccc_pkg.sv
src/ccc_in_if.sv
src/ccc_out_if.sv
src/cell_carrying_capacity.sv
bench/tb_cell_carrying_capacity.sv
